// ----- rtl/incremental_pid_hbridge_pwm_defines.svh -----
// Assertion macros shared by the incremental PID checker.
`ifndef INCREMENTAL_PID_HBRIDGE_PWM_DEFINES_SVH
`define INCREMENTAL_PID_HBRIDGE_PWM_DEFINES_SVH

// General form: explicit clock and active-low reset.
`define IPID_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Short form for modules that use the house clock and reset names.
`define IPID_ASSERT_CLK(label, prop, msg) \
    `IPID_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

// ----- rtl/ipid_pkg.sv -----
// Package: shared constants, types and codes of the incremental PID block.
package ipid_pkg;

    localparam int GAIN_W          = 16;          // config register width
    localparam int GREG_W          = GAIN_W + 1;  // holds 1.0 at 16 fraction bits
    localparam int GSUM_W          = GREG_W + 2;  // kp + ki + kd, kp + 2*kd
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int GAIN_FRAC_DEF   = 12;
    localparam int CFG_IDX_W       = 2;
    localparam int QUEUE_DEPTH     = 2;

    // clamp threshold 4.90/5.00 of full scale, clamp value 4.99/5.00
    localparam int LIMIT_NUM = 490;
    localparam int LIMIT_DEN = 500;
    localparam int CAP_NUM   = 499;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP = 2'd0,
        CFG_KI = 2'd1,
        CFG_KD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [GREG_W-1:0] kp;
        logic [GREG_W-1:0] ki;
        logic [GREG_W-1:0] kd;
    } t_gains;

    typedef struct packed {
        logic fwd;
        logic rev;
    } t_dir;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL1,
        BK_MUL2,
        BK_FINISH
    } t_back_state;

endpackage

// ----- rtl/ipid_in_if.sv -----
// Interface: input sample channel (setpoint and position).
interface ipid_in_if #(
    parameter int SAMPLE_BITS = ipid_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] setpoint_sample;
    logic [SAMPLE_BITS-1:0] position_sample;

    modport source (output valid, setpoint_sample, position_sample, input ready);
    modport sink   (input valid, setpoint_sample, position_sample, output ready);
endinterface

// ----- rtl/ipid_out_if.sv -----
// Interface: output duty channel toward the H-bridge.
interface ipid_out_if #(
    parameter int SAMPLE_BITS = ipid_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] forward_duty;
    logic [SAMPLE_BITS-1:0] reverse_duty;
    logic                   forward_active;
    logic                   reverse_active;

    modport source (output valid, forward_duty, reverse_duty, forward_active,
                    reverse_active, input ready);
    modport sink   (input valid, forward_duty, reverse_duty, forward_active,
                    reverse_active, output ready);
endinterface

// ----- rtl/incremental_pid_hbridge_pwm.sv -----
// The back end handles one sample pair at a time on a single shared multiplier
//   (three products per update plus the clamp/writeback state) and holds its
//   result in the finish state while the output is stalled.
// A 2-entry queue lets the input take transactions while the back end works.
// Reset (i_rst_n low, synchronous): queue emptied, error history and stored
//   output zeroed, gains back to kp = 1.0, ki*T = kd/T = 0.2.
module incremental_pid_hbridge_pwm #(
    parameter int SAMPLE_BITS        = ipid_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRACTION_BITS = ipid_pkg::GAIN_FRAC_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // gain register writes
    input  logic                           i_cfg_wr_en,
    input  logic [ipid_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ipid_pkg::GAIN_W-1:0]    i_cfg_wr_data,
    // sample pairs in, duty commands out
    ipid_in_if.sink                        i_sample,
    ipid_out_if.source                     o_duty
);
    import ipid_pkg::*;

    localparam int Q_W = SAMPLE_BITS + 3;  // error (S+1) plus direction flags

    // reset gains: 1.0 and 1.0/5 at the configured fraction width
    localparam logic [31:0] ONE_Q = 32'(1) << GAIN_FRACTION_BITS;
    localparam logic [31:0] FIFTH = ONE_Q / 32'd5;
    localparam logic [GREG_W-1:0] KP_RST = ONE_Q[GREG_W-1:0];
    localparam logic [GREG_W-1:0] KI_RST = FIFTH[GREG_W-1:0];
    localparam logic [GREG_W-1:0] KD_RST = FIFTH[GREG_W-1:0];

    t_gains r_gains;

    logic           push, pop, q_full, q_empty;
    logic [Q_W-1:0] push_data, pop_data;

    // Gain registers. Writes go straight in; index codes outside the list
    // are dropped. The user must write only while the loop is quiet; not enforced here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp <= KP_RST;
            r_gains.ki <= KI_RST;
            r_gains.kd <= KD_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KP:  r_gains.kp <= GREG_W'(i_cfg_wr_data);
                CFG_KI:  r_gains.ki <= GREG_W'(i_cfg_wr_data);
                CFG_KD:  r_gains.kd <= GREG_W'(i_cfg_wr_data);
                default: ;
            endcase
        end
    end

    // front: error and drive side per transaction
    ipid_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_sample    (i_sample),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (q_full)
    );

    // decoupling queue
    ipid_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (q_empty)
    );

    // back: PID update, clamp at 4.90 V to 4.99 V, duty steering
    ipid_back #(
        .SAMPLE_BITS        (SAMPLE_BITS),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_gains    (r_gains),
        .i_empty    (q_empty),
        .i_pop_data (pop_data),
        .o_pop      (pop),
        .o_duty     (o_duty)
    );
endmodule

// ----- rtl/ipid_fifo.sv -----
// Small register queue between the front and back ends.
module ipid_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ipid_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_FULL);
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end
endmodule

// ----- rtl/ipid_front.sv -----
// Front end: takes sample pairs, forms the signed error and the drive side.
module ipid_front #(
    parameter int SAMPLE_BITS = ipid_pkg::SAMPLE_BITS_DEF
) (
    ipid_in_if.sink            i_sample,
    output logic               o_push,
    output logic [SAMPLE_BITS+2:0] o_push_data,
    input  logic               i_full
);
    import ipid_pkg::*;

    localparam int ERR_W = SAMPLE_BITS + 1;

    logic signed [ERR_W-1:0] err;
    t_dir                    dir;

    assign i_sample.ready = !i_full;
    assign o_push         = i_sample.valid && !i_full;

    // error = position - setpoint, in counts
    assign err = $signed({1'b0, i_sample.position_sample})
               - $signed({1'b0, i_sample.setpoint_sample});

    assign dir.fwd = (i_sample.position_sample < i_sample.setpoint_sample);
    assign dir.rev = (i_sample.position_sample > i_sample.setpoint_sample);

    assign o_push_data = {err, dir};
endmodule

// ----- rtl/ipid_back.sv -----
// Back end: velocity-form PID update on a shared multiplier, clamp, duty out.
module ipid_back #(
    parameter int SAMPLE_BITS        = ipid_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRACTION_BITS = ipid_pkg::GAIN_FRAC_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ipid_pkg::t_gains       i_gains,
    input  logic                   i_empty,
    input  logic [SAMPLE_BITS+2:0] i_pop_data,
    output logic                   o_pop,
    ipid_out_if.source             o_duty
);
    import ipid_pkg::*;

    localparam int S       = SAMPLE_BITS;
    localparam int F       = GAIN_FRACTION_BITS;
    localparam int ERR_W   = S + 1;
    localparam int MUL_W   = ERR_W + GSUM_W + 1;
    localparam int ACC_W   = MUL_W + 2;
    localparam int UPREV_W = S + F + 2;

    localparam logic [63:0] THRESH =
        ((64'(LIMIT_NUM) << (S + F)) + 64'(LIMIT_DEN - 1)) / 64'(LIMIT_DEN);
    localparam logic [63:0] CAP     = (64'(CAP_NUM) << S) / 64'(LIMIT_DEN);
    localparam logic [63:0] CAP_SH  = CAP << F;
    localparam logic [ACC_W-1:0]   THRESH_A = THRESH[ACC_W-1:0];
    localparam logic [S-1:0]       CAP_DUTY = CAP[S-1:0];
    localparam logic [UPREV_W-1:0] CAP_U    = CAP_SH[UPREV_W-1:0];

    t_back_state r_state, n_state;

    logic signed [ERR_W-1:0]   r_e0, r_e1, r_e2;
    logic signed [UPREV_W-1:0] r_uprev;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [MUL_W-1:0]   r_prod;
    t_dir                      r_dir;

    logic                      r_out_valid;
    logic [S-1:0]              r_fwd_duty, r_rev_duty;
    logic                      r_fwd_act, r_rev_act;

    logic signed [ERR_W-1:0]   head_err;
    t_dir                      head_dir;
    logic [GSUM_W-1:0]         g_a, g_b, g_c;
    logic signed [ERR_W-1:0]   mul_a;
    logic [GSUM_W-1:0]         mul_g;
    logic signed [MUL_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]   prod_x, uprev_x, u_sum;
    logic [ACC_W-1:0]          mag;
    logic                      clamp;
    logic [S-1:0]              duty;
    logic signed [UPREV_W-1:0] u_store;
    logic                      out_free;
    logic                      finish;

    assign head_err = $signed(i_pop_data[S+2:2]);
    assign head_dir = i_pop_data[1:0];

    // combined gains
    assign g_a = GSUM_W'(i_gains.kp) + GSUM_W'(i_gains.ki) + GSUM_W'(i_gains.kd);
    assign g_b = GSUM_W'(i_gains.kp) + (GSUM_W'(i_gains.kd) << 1);
    assign g_c = GSUM_W'(i_gains.kd);

    always_comb begin
        case (r_state)
            BK_MUL1: begin
                mul_a = r_e1;
                mul_g = g_b;
            end
            BK_MUL2: begin
                mul_a = r_e2;
                mul_g = g_c;
            end
            default: begin
                mul_a = head_err;
                mul_g = g_a;
            end
        endcase
    end

    assign mul_p   = mul_a * $signed({1'b0, mul_g});
    assign prod_x  = {{(ACC_W-MUL_W){r_prod[MUL_W-1]}}, r_prod};
    assign uprev_x = {{(ACC_W-UPREV_W){r_uprev[UPREV_W-1]}}, r_uprev};

    // final sum, magnitude and clamp
    assign u_sum = r_acc + prod_x;
    assign mag   = u_sum[ACC_W-1] ? ACC_W'(-u_sum) : ACC_W'(u_sum);
    assign clamp = (mag >= THRESH_A);
    assign duty  = clamp ? CAP_DUTY : mag[F +: S];
    always_comb begin
        if (clamp) begin
            u_store = u_sum[ACC_W-1] ? -$signed(CAP_U) : $signed(CAP_U);
        end else begin
            u_store = u_sum[UPREV_W-1:0];
        end
    end

    assign out_free = !r_out_valid || o_duty.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        finish  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_MUL1;
                end
            end
            BK_MUL1: n_state = BK_MUL2;
            BK_MUL2: n_state = BK_FINISH;
            BK_FINISH: begin
                if (out_free) begin
                    finish  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    r_e0   <= head_err;
                    r_dir  <= head_dir;
                    r_acc  <= uprev_x;
                    r_prod <= mul_p;
                end
            end
            BK_MUL1: begin
                r_acc  <= r_acc + prod_x;
                r_prod <= mul_p;
            end
            BK_MUL2: begin
                r_acc  <= r_acc - prod_x;
                r_prod <= mul_p;
            end
            default: ;
        endcase
        if (finish) begin
            r_fwd_duty <= r_dir.fwd ? duty : '0;
            r_rev_duty <= r_dir.rev ? duty : '0;
            r_fwd_act  <= r_dir.fwd;
            r_rev_act  <= r_dir.rev;
        end
    end

    // controller history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1    <= '0;
            r_e2    <= '0;
            r_uprev <= '0;
        end else if (finish) begin
            r_e1    <= r_e0;
            r_e2    <= r_e1;
            r_uprev <= u_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_duty.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_duty.valid          = r_out_valid;
    assign o_duty.forward_duty   = r_fwd_duty;
    assign o_duty.reverse_duty   = r_rev_duty;
    assign o_duty.forward_active = r_fwd_act;
    assign o_duty.reverse_active = r_rev_act;
endmodule

// ----- rtl/ipid_checker.sv -----
// Port-level checker for the incremental PID block, with its bind.
`include "incremental_pid_hbridge_pwm_defines.svh"

module ipid_checker #(
    parameter int SAMPLE_BITS = ipid_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_fwd_duty,
    input logic [SAMPLE_BITS-1:0] i_rev_duty,
    input logic                   i_fwd_act,
    input logic                   i_rev_act
);
    import ipid_pkg::*;

    localparam logic [63:0] CAP = (64'(CAP_NUM) << SAMPLE_BITS) / 64'(LIMIT_DEN);
    localparam logic [SAMPLE_BITS-1:0] CAP_DUTY = CAP[SAMPLE_BITS-1:0];

    // stalled result transaction holds
    `IPID_ASSERT_CLK(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fwd_duty) && $stable(i_rev_duty) && $stable(i_fwd_act) && $stable(i_rev_act), "output changed while stalled")
    // never drive both bridge sides
    `IPID_ASSERT_CLK(a_one_side, i_out_valid |-> !(i_fwd_act && i_rev_act), "both sides active")
    // inactive side carries zero duty
    `IPID_ASSERT_CLK(a_idle_zero, i_out_valid |-> (i_fwd_act || i_fwd_duty == '0) && (i_rev_act || i_rev_duty == '0), "duty on inactive side")
    // duty never exceeds the 4.99 V cap
    `IPID_ASSERT_CLK(a_duty_cap, i_out_valid |-> (i_fwd_duty <= CAP_DUTY) && (i_rev_duty <= CAP_DUTY), "duty above cap")
endmodule

bind incremental_pid_hbridge_pwm ipid_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_ipid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_duty.valid),
    .i_out_ready (o_duty.ready),
    .i_fwd_duty  (o_duty.forward_duty),
    .i_rev_duty  (o_duty.reverse_duty),
    .i_fwd_act   (o_duty.forward_active),
    .i_rev_act   (o_duty.reverse_active)
);

// ----- bench/ipid_duty_checker.sv -----
// Duty command checker: mirrors the PID state, predicts each duty command and compares.
module ipid_duty_checker #(
    parameter int SAMPLE_BITS        = ipid_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRACTION_BITS = ipid_pkg::GAIN_FRAC_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [ipid_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ipid_pkg::GAIN_W-1:0]    i_cfg_wr_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [SAMPLE_BITS-1:0]         i_setpoint,
    input  logic [SAMPLE_BITS-1:0]         i_position,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [SAMPLE_BITS-1:0]         i_forward_duty,
    input  logic [SAMPLE_BITS-1:0]         i_reverse_duty,
    input  logic                           i_forward_active,
    input  logic                           i_reverse_active,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ipid_pkg::*;

    // clamp when |u| reaches 4.90/5.00 of full scale, clamp to 4.99/5.00
    localparam longint CLAMP_NUM  = 490;
    localparam longint CLAMP_DEN  = 500;
    localparam longint CAP_COUNTS = (longint'(499) << SAMPLE_BITS) / 500;
    localparam int     MAX_PRINTED = 50;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] forward_duty;
        logic [SAMPLE_BITS-1:0] reverse_duty;
        logic                   forward_active;
        logic                   reverse_active;
    } duty_cmd_t;

    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [GAIN_W-1:0] kd_gain;
    longint            err_last;   // e1
    longint            err_older;  // e2
    longint            u_last;     // stored output, GAIN_FRACTION_BITS fraction bits
    duty_cmd_t         duty_expected_q[$];
    int                fail_count = 0;
    int                out_count  = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < MAX_PRINTED)
            $display("%0t ns mismatch: %s got %0d expected %0d (output transaction %0d)",
                     $time, what, got, want, out_count);
        fail_count++;
    endtask

    // Velocity-form update; advances the error history and stored output.
    function automatic duty_cmd_t pid_update(input logic [SAMPLE_BITS-1:0] setpoint,
                                             input logic [SAMPLE_BITS-1:0] position);
        longint    e_now;
        longint    sum_a;
        longint    sum_b;
        longint    u;
        longint    mag;
        longint    duty;
        duty_cmd_t cmd;
        e_now = longint'(position) - longint'(setpoint);
        sum_a = longint'(kp_gain) + longint'(ki_gain) + longint'(kd_gain);
        sum_b = longint'(kp_gain) + 2 * longint'(kd_gain);
        u = u_last + e_now * sum_a - err_last * sum_b + err_older * longint'(kd_gain);
        mag = (u < 0) ? -u : u;
        if (mag * CLAMP_DEN >= (CLAMP_NUM << (SAMPLE_BITS + GAIN_FRACTION_BITS))) begin
            u = (u < 0) ? -(CAP_COUNTS << GAIN_FRACTION_BITS)
                        : (CAP_COUNTS << GAIN_FRACTION_BITS);
            duty = CAP_COUNTS;
        end else begin
            duty = mag >> GAIN_FRACTION_BITS;
        end
        u_last    = u;
        err_older = err_last;
        err_last  = e_now;
        // side follows the sample comparison only, not the sign of u
        cmd = '0;
        if (position < setpoint) begin
            cmd.forward_duty   = duty[SAMPLE_BITS-1:0];
            cmd.forward_active = 1'b1;
        end else if (position > setpoint) begin
            cmd.reverse_duty   = duty[SAMPLE_BITS-1:0];
            cmd.reverse_active = 1'b1;
        end
        return cmd;
    endfunction

    always @(posedge i_clk) begin
        duty_cmd_t got;
        duty_cmd_t want;
        if (!i_rst_n) begin
            kp_gain   = GAIN_W'(1 << GAIN_FRACTION_BITS);
            ki_gain   = GAIN_W'((1 << GAIN_FRACTION_BITS) / 5);
            kd_gain   = GAIN_W'((1 << GAIN_FRACTION_BITS) / 5);
            err_last  = 0;
            err_older = 0;
            u_last    = 0;
            duty_expected_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_KP: kp_gain = i_cfg_wr_data;
                    CFG_KI: ki_gain = i_cfg_wr_data;
                    CFG_KD: kd_gain = i_cfg_wr_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                duty_expected_q.push_back(pid_update(i_setpoint, i_position));
            if (i_out_valid && i_out_ready) begin
                got = {i_forward_duty, i_reverse_duty, i_forward_active, i_reverse_active};
                if (duty_expected_q.size() == 0) begin
                    report_mismatch("duty command with none pending", longint'(got), 0);
                end else begin
                    want = duty_expected_q.pop_front();
                    if (got.forward_duty !== want.forward_duty)
                        report_mismatch("forward_duty", got.forward_duty, want.forward_duty);
                    if (got.reverse_duty !== want.reverse_duty)
                        report_mismatch("reverse_duty", got.reverse_duty, want.reverse_duty);
                    if (got.forward_active !== want.forward_active)
                        report_mismatch("forward_active", got.forward_active,
                                        want.forward_active);
                    if (got.reverse_active !== want.reverse_active)
                        report_mismatch("reverse_active", got.reverse_active,
                                        want.reverse_active);
                end
                out_count++;
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= duty_expected_q.size();
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top: sample pair and gain write stimulus for the incremental PID, and the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ipid_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int GFB         = GAIN_FRAC_DEF;
    localparam int SAMPLE_MAX  = (1 << SB) - 1;
    localparam int GAIN_MAX    = (1 << GAIN_W) - 1;
    localparam int UNITY_GAIN  = 1 << GFB;
    // index 3 is not a register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    // after the last duty command, leave a margin before touching the gains
    localparam int SETTLE_CYCLES = 8;
    // the slowest correct run stays well below this limit
    localparam int CYCLE_LIMIT   = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_wr_data;
    bit                   gaps_on;      // random idling on both channels
    int                   stall_left;
    int                   cycle_count = 0;
    int                   fail_count;
    int                   pending_count;

    ipid_in_if  #(.SAMPLE_BITS(SB)) sample_if ();
    ipid_out_if #(.SAMPLE_BITS(SB)) duty_if ();

    incremental_pid_hbridge_pwm #(
        .SAMPLE_BITS        (SB),
        .GAIN_FRACTION_BITS (GFB)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wr_data (cfg_wr_data),
        .i_sample      (sample_if),
        .o_duty        (duty_if)
    );

    ipid_duty_checker #(
        .SAMPLE_BITS        (SB),
        .GAIN_FRACTION_BITS (GFB)
    ) duty_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_in_valid       (sample_if.valid),
        .i_in_ready       (sample_if.ready),
        .i_setpoint       (sample_if.setpoint_sample),
        .i_position       (sample_if.position_sample),
        .i_out_valid      (duty_if.valid),
        .i_out_ready      (duty_if.ready),
        .i_forward_duty   (duty_if.forward_duty),
        .i_reverse_duty   (duty_if.reverse_duty),
        .i_forward_active (duty_if.forward_active),
        .i_reverse_active (duty_if.reverse_active),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count)
    );

    always #6 i_clk = ~i_clk;

    // Duty side back-pressure: ready drops in random-length bursts while gaps
    // are enabled, and stays high otherwise.
    always @(posedge i_clk) begin
        if (!gaps_on) begin
            stall_left    <= 0;
            duty_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            duty_if.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 8);
            duty_if.ready <= 1'b0;
        end else begin
            duty_if.ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // One sample pair transaction. An optional idle burst goes first; valid
    // is left high on return so back-to-back pairs need no extra NBA on it.
    task automatic send_pair(input int setpoint, input int position);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        sample_if.valid           <= 1'b1;
        sample_if.setpoint_sample <= setpoint[SB-1:0];
        sample_if.position_sample <= position[SB-1:0];
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
    endtask

    // Mix of settled loops (equal samples), small tracking errors and
    // full-range jumps that push u into the clamp.
    task automatic send_random_pair();
        int setpoint;
        int position;
        int pick;
        pick     = $urandom_range(0, 9);
        setpoint = $urandom_range(0, SAMPLE_MAX);
        if (pick < 2) begin
            position = setpoint;
        end else if (pick < 6) begin
            position = setpoint + int'($urandom_range(0, 16)) - 8;
            if (position < 0) position = 0;
            if (position > SAMPLE_MAX) position = SAMPLE_MAX;
        end else begin
            position = $urandom_range(0, SAMPLE_MAX);
        end
        send_pair(setpoint, position);
    endtask

    // Drop valid, wait for every pending duty command, then let the pipe
    // go quiet. The first edge lets the checker's pending count catch up.
    task automatic settle();
        sample_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; load_gains lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= value[GAIN_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic load_gains(input int kp, input int ki, input int kd);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_KD, kd);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random_pair();
        settle();
    endtask

    initial begin
        // everything known before the first edge
        i_rst_n                   = 1'b0;
        cfg_wr_en                 = 1'b0;
        cfg_index                 = CFG_KP;
        cfg_wr_data               = '0;
        sample_if.valid           = 1'b0;
        sample_if.setpoint_sample = '0;
        sample_if.position_sample = '0;
        duty_if.ready             = 1'b0;
        gaps_on                   = 1'b1;
        stall_left                = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset gains (1.0, 0.2, 0.2): equal samples, full-scale errors of
        // both signs into the clamp, mid-range errors, then single-count errors.
        send_pair(0, 0);
        send_pair(0, SAMPLE_MAX);
        send_pair(SAMPLE_MAX, 0);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        send_pair(300, 700);
        send_pair(300, 700);
        // position just below setpoint while u is still large and positive:
        // the forward side must carry a duty taken from a positive u
        send_pair(401, 400);
        send_pair(400, 400);
        send_pair(400, 401);
        send_pair(400, 399);
        send_pair(511, 512);
        send_pair(SAMPLE_MAX, SAMPLE_MAX - 1);
        send_pair(0, 1);
        send_pair(1, 0);
        settle();

        // Pure proportional at unity: u moves by the change in error, in counts;
        // the clamp edge sits between 1003 (passes) and 1004 (clamped).
        load_gains(UNITY_GAIN, 0, 0);
        send_pair(0, 0);
        send_pair(0, 1003);
        send_pair(0, 1004);
        send_pair(1004, 0);
        send_pair(1003, 0);
        send_pair(0, 1003);
        send_pair(5, 5);
        send_pair(SAMPLE_MAX, 0);
        settle();

        // every gain at full scale: almost every update saturates
        load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
        run_random(250);

        // zero gains hold u where it was; a stray write to the unused index
        // must leave the gains alone
        write_reg(CFG_KP, 0);
        write_reg(CFG_KI, 0);
        write_reg(CFG_KD, 0);
        write_reg(CFG_UNUSED_IDX, $urandom_range(0, GAIN_MAX));
        cfg_wr_en <= 1'b0;
        run_random(150);

        load_gains($urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX),
                   $urandom_range(0, GAIN_MAX));
        run_random(250);

        // modest gains keep u off the clamp most of the time; no idling here
        gaps_on <= 1'b0;
        load_gains($urandom_range(0, 2 * UNITY_GAIN), $urandom_range(0, UNITY_GAIN),
                   $urandom_range(0, UNITY_GAIN));
        run_random(300);

        gaps_on <= 1'b1;
        load_gains(0, $urandom_range(1, UNITY_GAIN), 0);
        run_random(150);

        load_gains(0, 0, $urandom_range(1, UNITY_GAIN));
        run_random(150);

        // closing stretch at full rate on both sides
        gaps_on <= 1'b0;
        load_gains($urandom_range(0, 2 * UNITY_GAIN), $urandom_range(0, UNITY_GAIN / 2),
                   $urandom_range(0, UNITY_GAIN / 2));
        run_random(300);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
